>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/gpl_pkg.sv
// ----------------------------------------------------------------------------
// gpl_pkg
// Types, widths and calendar tables shared by the period length block.
// ----------------------------------------------------------------------------
package gpl_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 22;
  // Day numbers of years up to the largest 14-bit year stay below 2**23.
  localparam int unsigned ACC_W   = 23;
  localparam int unsigned ALU_W   = ACC_W + 1;
  // Quotient of a 14-bit year by one hundred.
  localparam int unsigned QUO_W   = 8;
  localparam int unsigned STEP_W  = 3;

  localparam int unsigned CENTURY       = 100;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned FEB_LEAP_LEN  = 29;
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic               bad_date;
  } out_item_t;

  typedef struct packed {
    logic sub;
  } alu_ctl_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             borrow;
  } alu_res_t;

  // Length of a month in a common year; zero for a code that is no month.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                       len = DAY_W'(28);
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  // Days before the first of the month in a year that starts on March 1.
  function automatic logic [8:0] march_offset(input logic [MONTH_W-1:0] m);
    logic [8:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

>>> src/gpl_addsub.sv
// ----------------------------------------------------------------------------
// gpl_addsub
// Shared adder and subtractor with borrow out for the day number sequencer.
// ----------------------------------------------------------------------------
module gpl_addsub (
  input  logic [gpl_pkg::ALU_W-1:0] a_i,
  input  logic [gpl_pkg::ALU_W-1:0] b_i,
  input  gpl_pkg::alu_ctl_t         ctl_i,
  output gpl_pkg::alu_res_t         res_o
);
  import gpl_pkg::*;

  logic [ALU_W:0]   full;
  logic [ALU_W-1:0] b_op;

  // Subtraction is addition of the one's complement with a carry in.
  assign b_op = ctl_i.sub ? ~b_i : b_i;
  assign full = {1'b0, a_i} + {1'b0, b_op} + (ALU_W + 1)'(ctl_i.sub);

  assign res_o.sum    = full[ALU_W-1:0];
  assign res_o.borrow = ctl_i.sub & ~full[ALU_W];

endmodule

>>> src/gregorian_period_length_days.sv
// ----------------------------------------------------------------------------
// gregorian_period_length_days: days between two Gregorian dates
// A new item is taken only once the sequencer is idle again, that is once
// the last result has moved to the output register; the single shared adder
// carries two 8-step divisions by 100 and all day number sums. Reset clears
// the sequencer and output valid and sets include_end_day to 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gregorian_period_length_days #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gpl_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gpl_pkg::out_item_t out_item_o
);
  import gpl_pkg::*;

  // The sequencer walks each date through a division of its year by one
  // hundred and then five accumulation steps that form a day number:
  //   yy*365 + yy/4 - yy/100 + yy/400 + march_offset(m) + d
  // where yy is the year, less one for January and February. The origin of
  // that count is arbitrary, which is fine since only the difference of the
  // two day numbers leaves the block.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_ACCUM = 5'b00100,
    S_DIFF  = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  // Accumulation steps.
  localparam logic [STEP_W-1:0] ACC_MUL  = STEP_W'(0);
  localparam logic [STEP_W-1:0] ACC_QTR  = STEP_W'(1);
  localparam logic [STEP_W-1:0] ACC_CENT = STEP_W'(2);
  localparam logic [STEP_W-1:0] ACC_QUAD = STEP_W'(3);
  localparam logic [STEP_W-1:0] ACC_DOY  = STEP_W'(4);
  // The division produces one quotient bit a cycle, most significant first.
  localparam logic [STEP_W-1:0] DIV_FIRST = STEP_W'(QUO_W - 1);

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q;
  logic                sel_q;        // 0 while the start date is worked on
  logic                bad_q;
  logic                include_q;
  logic                out_valid_q;
  in_item_t            in_q;
  out_item_t           out_q;
  logic [YEAR_W-1:0]   rem_q;
  logic [QUO_W-1:0]    quo_q;
  logic [ACC_W-1:0]    acc_q;
  logic [ACC_W-1:0]    start_dn_q;

  logic                in_xfer;
  logic                out_xfer;
  logic                out_load;
  logic [DAY_W-1:0]    cur_d;
  logic [MONTH_W-1:0]  cur_m;
  logic [YEAR_W-1:0]   cur_y;
  logic                early;
  logic                rem_zero;
  logic                leap;
  logic [DAY_W-1:0]    cur_len;
  logic                date_ok;
  logic [YEAR_W-1:0]   yy;
  logic [QUO_W-1:0]    quo_adj;
  logic [ALU_W-1:0]    alu_a;
  logic [ALU_W-1:0]    alu_b;
  alu_ctl_t            alu_ctl;
  alu_res_t            alu_res;
  logic [ACC_W-1:0]    fin_sum;
  logic [COUNT_W-1:0]  fin_count;

  // The input side is free whenever the sequencer is idle; a finished result
  // may still wait in the output register meanwhile.
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_xfer    = out_valid_q & ~out_stall_i;
  assign out_load    = (state_q == S_FIN) & (~out_valid_q | ~out_stall_i);

  // Fields of the date currently worked on.
  assign cur_d = sel_q ? in_q.end_day   : in_q.start_day;
  assign cur_m = sel_q ? in_q.end_month : in_q.start_month;
  assign cur_y = sel_q ? in_q.end_year  : in_q.start_year;

  // After the division rem_q and quo_q hold the year modulo and over 100,
  // which also decide whether the year is a leap year.
  assign rem_zero = (rem_q == '0);
  assign leap     = (~rem_zero & (cur_y[1:0] == 2'b00)) |
                    (rem_zero & (quo_q[1:0] == 2'b00));
  assign cur_len  = ((cur_m == MONTH_FEB) && leap) ? DAY_W'(FEB_LEAP_LEN)
                                                   : month_len(cur_m);
  assign date_ok  = (cur_m != '0) && (cur_m <= MONTH_DEC) &&
                    (cur_y != '0) && (32'(cur_y) <= MAX_YEAR) &&
                    (cur_d != '0) && (cur_d <= cur_len);

  // January and February count with the previous year. When the year is a
  // multiple of one hundred, stepping back one year also lowers its century.
  assign early   = (cur_m <= MONTH_FEB);
  assign yy      = cur_y - YEAR_W'(early);
  assign quo_adj = quo_q - QUO_W'(early & rem_zero);

  // Operand selection for the shared adder.
  always_comb begin
    alu_a       = '0;
    alu_b       = '0;
    alu_ctl.sub = 1'b0;
    case (state_q)
      S_DIV: begin
        // Trial subtraction of 100 shifted to the current quotient bit.
        alu_a       = ALU_W'(rem_q);
        alu_b       = ALU_W'(CENTURY) << step_q;
        alu_ctl.sub = 1'b1;
      end
      S_ACCUM: begin
        alu_a = ALU_W'(acc_q);
        case (step_q)
          ACC_MUL: begin
            alu_a = '0;
            alu_b = ALU_W'(ACC_W'(yy) * ACC_W'(DAYS_PER_YEAR));
          end
          ACC_QTR:  alu_b = ALU_W'(yy >> 2);
          ACC_CENT: begin
            alu_b       = ALU_W'(quo_adj);
            alu_ctl.sub = 1'b1;
          end
          ACC_QUAD: alu_b = ALU_W'(quo_adj >> 2);
          ACC_DOY:  alu_b = ALU_W'(march_offset(cur_m)) + ALU_W'(cur_d);
          default:  alu_b = '0;
        endcase
      end
      S_DIFF: begin
        alu_a       = ALU_W'(acc_q);
        alu_b       = ALU_W'(start_dn_q);
        alu_ctl.sub = 1'b1;
      end
      S_FIN: begin
        alu_a = ALU_W'(acc_q);
        alu_b = ALU_W'(include_q);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  gpl_addsub u_addsub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .ctl_i (alu_ctl),
    .res_o (alu_res)
  );

  // A count beyond the output width saturates to all ones.
  assign fin_sum   = alu_res.sum[ACC_W-1:0];
  assign fin_count = fin_sum[ACC_W-1] ? '1 : fin_sum[COUNT_W-1:0];

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_DIV;
      S_DIV:   if (step_q == '0) state_d = S_ACCUM;
      S_ACCUM: begin
        if (step_q == ACC_DOY) begin
          state_d = sel_q ? S_DIFF : S_DIV;
        end
      end
      S_DIFF:  state_d = S_FIN;
      S_FIN:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      sel_q       <= 1'b0;
      include_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        include_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            step_q <= DIV_FIRST;
            sel_q  <= 1'b0;
          end
        end
        S_DIV: begin
          step_q <= (step_q == '0) ? ACC_MUL : step_q - STEP_W'(1);
        end
        S_ACCUM: begin
          if (step_q == ACC_DOY) begin
            step_q <= DIV_FIRST;
            sel_q  <= 1'b1;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        default: step_q <= step_q;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          in_q  <= in_item_i;
          rem_q <= in_item_i.start_year;
          bad_q <= 1'b0;
        end
      end
      S_DIV: begin
        // Restoring division: keep the difference when nothing was borrowed.
        if (!alu_res.borrow) begin
          rem_q <= alu_res.sum[YEAR_W-1:0];
        end
        quo_q <= {quo_q[QUO_W-2:0], ~alu_res.borrow};
      end
      S_ACCUM: begin
        acc_q <= alu_res.sum[ACC_W-1:0];
        if (step_q == ACC_MUL) begin
          bad_q <= bad_q | ~date_ok;
        end
        if ((step_q == ACC_DOY) && !sel_q) begin
          start_dn_q <= alu_res.sum[ACC_W-1:0];
          rem_q      <= in_q.end_year;
        end
      end
      S_DIFF: begin
        // A start on or after the end gives a difference of zero.
        acc_q <= alu_res.borrow ? '0 : alu_res.sum[ACC_W-1:0];
      end
      S_FIN: begin
        if (out_load) begin
          out_q.day_count <= bad_q ? '0 : fin_count;
          out_q.bad_date  <= bad_q;
        end
      end
      default: acc_q <= acc_q;
    endcase
  end

  // An impossible date always reports a zero count.
  `ASSERT_CLK(a_bad_zero, out_valid_o && out_item_o.bad_date |-> out_item_o.day_count == '0, "bad date with nonzero count")
  // Accumulation always starts right after a finished division.
  `ASSERT_CLK(a_div_first, (state_q == S_ACCUM) && (step_q == ACC_MUL) |-> $past(state_q) == S_DIV, "accumulation without division")
  // An input transfer starts the division at its top quotient bit.
  `ASSERT_CLK(a_start, in_xfer |=> (state_q == S_DIV) && (step_q == DIV_FIRST), "input transfer did not start the division")
  // A taken result leaves the output empty unless a new one is loaded.
  `ASSERT_CLK(a_out_drain, out_xfer && (state_q != S_FIN) |=> !out_valid_o, "result repeated")
  // No result is offered during reset.
  `ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for gregorian_period_length_days
// Drives date pairs through the valid/stall input channel and compares each
// output transfer with a day-count predictor kept inside the bench. Traffic
// arrives in bursts with gaps, the receiver stalls in changing patterns, and
// the include-end-day register is switched between phases of the run.
// ----------------------------------------------------------------------------
module testbench;
  import gpl_pkg::*;

  // Default year limit of the block; later years are impossible dates.
  localparam int unsigned LAST_YEAR    = 9999;
  localparam int unsigned COUNT_ALL    = (1 << COUNT_W) - 1;
  // The watchdog gives up after this many cycles without any transfer
  // while work is still outstanding.
  localparam int unsigned IDLE_LIMIT   = 4000;
  // Quiet cycles kept at the end so that a stray late result is still seen.
  localparam int unsigned DRAIN_CYCLES = 60;
  // One long receiver hold-off, started once this many results have gone by.
  localparam int unsigned HOLD_AFTER   = 350;
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned MAX_REPORTS  = 10;

  // A predicted result together with the dates that caused it, so that a
  // mismatch report can show the input as well.
  typedef struct packed {
    in_item_t  dates;
    out_item_t length;
  } period_check_t;

  // Reset starts released and is pulled low at the first rising edge, so
  // that the falling edge really reaches the asynchronous reset of the block.
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b1;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Date pairs waiting to be offered, and predictions waiting for results.
  in_item_t      pending_dates[$];
  period_check_t expected_lengths[$];

  // Bench copy of the include-end-day register; it resets to 1 like the block.
  logic        end_day_included = 1'b1;
  int unsigned mismatches       = 0;

  gregorian_period_length_days dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Calendar predictor
  // --------------------------------------------------------------------------

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % CENTURY != 0)) || (y % 400 == 0);
  endfunction

  // Callers only pass months 1 to 12.
  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    case (m)
      2:           return leap_year(y) ? FEB_LEAP_LEN : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic bit date_ok(input int unsigned d, input int unsigned m,
                                 input int unsigned y);
    if (m < 1 || m > 12 || y < 1 || y > LAST_YEAR) return 1'b0;
    return (d >= 1) && (d <= days_in_month(m, y));
  endfunction

  // Days since the day before January 1 of year 1. Only differences matter,
  // so any fixed origin works.
  function automatic int unsigned day_serial(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned py;
    int unsigned n;
    py = y - 1;
    n  = py * DAYS_PER_YEAR + py / 4 - py / CENTURY + py / 400;
    for (int unsigned k = 1; k < m; k++) n += days_in_month(k, y);
    return n + d;
  endfunction

  function automatic out_item_t period_length(input in_item_t it, input logic incl);
    out_item_t   r;
    int unsigned first;
    int unsigned last;
    int unsigned n;
    r = '0;
    if (!date_ok(it.start_day, it.start_month, it.start_year) ||
        !date_ok(it.end_day, it.end_month, it.end_year)) begin
      // An impossible date on either side flags the item and zeroes the count.
      r.bad_date = 1'b1;
    end else begin
      first = day_serial(it.start_day, it.start_month, it.start_year);
      last  = day_serial(it.end_day, it.end_month, it.end_year);
      // A start that is not before the end counts as zero days.
      n = (first < last) ? last - first : 0;
      n += incl;
      if (n > COUNT_ALL) n = COUNT_ALL;
      r.day_count = COUNT_W'(n);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic add_period(input int unsigned sd, input int unsigned sm,
                            input int unsigned sy, input int unsigned ed,
                            input int unsigned em, input int unsigned ey);
    in_item_t it;
    it.start_day   = DAY_W'(sd);
    it.start_month = MONTH_W'(sm);
    it.start_year  = YEAR_W'(sy);
    it.end_day     = DAY_W'(ed);
    it.end_month   = MONTH_W'(em);
    it.end_year    = YEAR_W'(ey);
    pending_dates.push_back(it);
  endtask

  // Years are drawn so that leap rules get exercised often: plain random
  // years, century years, multiples of four, and both ends of the range.
  function automatic int unsigned pick_year();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, LAST_YEAR);
      1:       return CENTURY * $urandom_range(1, 99);
      2:       return 4 * $urandom_range(1, 2499);
      default: return $urandom_range(0, 1) ? $urandom_range(1, 20)
                                           : $urandom_range(LAST_YEAR - 20, LAST_YEAR);
    endcase
  endfunction

  // Mostly well-formed date pairs, some with one field broken on purpose,
  // and a share of raw noise over every bit of the item.
  function automatic in_item_t random_period();
    in_item_t    it;
    logic [63:0] raw;
    int unsigned pick;
    int unsigned sy;
    int unsigned ey;
    int unsigned sm;
    int unsigned em;
    pick = $urandom_range(0, 99);
    if (pick >= 92) begin
      raw = {$urandom, $urandom};
      it  = raw[$bits(in_item_t)-1:0];
      return it;
    end
    sy = pick_year();
    case ($urandom_range(0, 2))
      0: ey = pick_year();
      1: begin
        // Nearby years give small counts and frequent reversed pairs.
        ey = sy + $urandom_range(0, 4);
        ey = (ey > 2) ? ey - 2 : 1;
        if (ey > LAST_YEAR) ey = LAST_YEAR;
      end
      default: ey = sy;
    endcase
    sm = $urandom_range(1, 12);
    em = $urandom_range(1, 12);
    it.start_year  = YEAR_W'(sy);
    it.start_month = MONTH_W'(sm);
    it.start_day   = DAY_W'($urandom_range(1, days_in_month(sm, sy)));
    it.end_year    = YEAR_W'(ey);
    it.end_month   = MONTH_W'(em);
    it.end_day     = DAY_W'($urandom_range(1, days_in_month(em, ey)));
    if (pick >= 85) begin
      case ($urandom_range(0, 3))
        0: it.start_day = $urandom_range(0, 1) ? DAY_W'(0)
                                               : DAY_W'(days_in_month(sm, sy) + 1);
        1: it.end_month = $urandom_range(0, 1) ? MONTH_W'(0)
                                               : MONTH_W'($urandom_range(13, 15));
        2: it.start_year = $urandom_range(0, 1) ? YEAR_W'(0)
                           : YEAR_W'($urandom_range(LAST_YEAR + 1, (1 << YEAR_W) - 1));
        default: it.end_day = (days_in_month(em, ey) == 31) ? DAY_W'(0)
                              : DAY_W'($urandom_range(days_in_month(em, ey) + 1, 31));
      endcase
    end
    return it;
  endfunction

  task automatic queue_random_periods(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) pending_dates.push_back(random_period());
  endtask

  // Returns at a falling edge once every queued item has been transferred
  // and every predicted result has come back.
  task automatic wait_drained();
    while (pending_dates.size() != 0 || in_valid || expected_lengths.size() != 0)
      @(negedge clk);
  endtask

  // The register is only written while the block holds no work.
  task automatic write_end_day_reg(input logic v);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    end_day_included = v;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    @(posedge clk);
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pairs with the register at its reset value of 1.
    add_period( 1,  1,    1,  1,  1,    1);  // same date
    add_period( 1,  1,    1, 31, 12, 9999);  // widest possible span
    add_period(31, 12, 9999,  1,  1,    1);  // end before start
    add_period(28,  2, 2023,  1,  3, 2023);  // common February
    add_period(28,  2, 2024,  1,  3, 2024);  // leap February
    add_period(29,  2, 2000,  1,  3, 2000);  // century year divisible by 400
    add_period(29,  2, 1900,  1,  3, 1900);  // century year that is not leap
    add_period(29,  2, 2023,  1,  1, 2024);  // leap day in a common year
    add_period( 0,  1, 2020,  1,  1, 2021);  // day zero
    add_period(31,  4, 2020,  1,  5, 2020);  // day past a 30-day month
    add_period(30,  4, 2020,  1,  5, 2020);  // last day of a 30-day month
    add_period( 1,  0, 2020,  1,  1, 2021);  // month zero
    add_period( 1, 13, 2020,  1,  1, 2021);  // month past December
    add_period( 1,  1, 2020, 31, 15, 16383); // end fields all ones
    add_period( 1,  1,    0,  1,  1, 2020);  // year zero
    add_period( 1,  1, 10000, 1,  1, 2020);  // year past the limit
    add_period(31, 12, 9998,  1,  1, 9999);  // year boundary at the top
    add_period( 1,  1, 2020,  0,  1, 2021);  // impossible end date only
    add_period(31,  1, 1999, 31,  1, 2000);  // one year ending before a leap day
    add_period( 1,  3, 1600,  1,  3, 2000);  // one full 400-year cycle
    add_period(15,  6, 2000, 14,  6, 2000);  // start one day after the end
    add_period(31, 15, 16383, 31, 15, 16383); // every field all ones

    // Random phases, switching the register between its two values. Each
    // switch waits for the block to drain completely first.
    write_end_day_reg(1'b0);
    queue_random_periods(260);
    write_end_day_reg(1'b1);
    queue_random_periods(280);
    write_end_day_reg(1'b0);
    queue_random_periods(260);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_lengths.size() != 0) begin
      $display("%0d expected results never arrived", expected_lengths.size());
      mismatches += expected_lengths.size();
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input driver: bursts of back-to-back items separated by random gaps.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    // The payload only moves on once the current transfer has completed.
    if (rst_n && (!in_valid || !in_stall)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_dates.size() != 0) begin
        in_item  <= pending_dates.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // A quarter of the bursts are followed directly by the next one.
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output receiver: stall patterns that change from segment to segment,
  // plus one long hold-off that backs the block up into its input.
  // --------------------------------------------------------------------------
  int unsigned results_taken = 0;
  int unsigned seg_left      = 0;
  int unsigned stall_mode    = 0;
  int unsigned hold_left     = 0;
  bit          hold_started  = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) results_taken++;
      if (!hold_started && results_taken >= HOLD_AFTER) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left   = $urandom_range(20, 200);
          stall_mode = $urandom_range(0, 2);
        end else begin
          seg_left--;
        end
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on each input transfer and checks each output transfer
  // against the oldest prediction still waiting.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    period_check_t want;
    if (rst_n) begin
      // The result is checked first; it comes from the output register, so it
      // can never belong to an input transferred in the same cycle.
      if (out_valid && !out_stall) begin
        if (expected_lengths.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: count %0d bad_date %0b",
                     out_item.day_count, out_item.bad_date);
        end else begin
          want = expected_lengths.pop_front();
          if (out_item.day_count !== want.length.day_count ||
              out_item.bad_date !== want.length.bad_date) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0d-%0d-%0d to %0d-%0d-%0d: expected count %0d bad_date %0b, %s %0d %s %0b",
                       want.dates.start_year, want.dates.start_month, want.dates.start_day,
                       want.dates.end_year, want.dates.end_month, want.dates.end_day,
                       want.length.day_count, want.length.bad_date,
                       "got count", out_item.day_count, "bad_date", out_item.bad_date);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want.dates  = in_item;
        want.length = period_length(in_item, end_day_included);
        expected_lengths.push_back(want);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles without any transfer while work is outstanding.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (pending_dates.size() == 0 && !in_valid && expected_lengths.size() == 0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
